### src/windowed_peak_with_parabolic_refine_core_macros.svh
// Assertion macros for the windowed peak core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef WINDOWED_PEAK_WITH_PARABOLIC_REFINE_CORE_MACROS_SVH
`define WINDOWED_PEAK_WITH_PARABOLIC_REFINE_CORE_MACROS_SVH

// same-cycle implication
`define WPPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WPPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/wppr_pkg.sv
// Shared constants and codes for the windowed peak core.
// No dependencies; used by every other file of the block but the assertion macro header.
`timescale 1ns / 1ps

package wppr_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int FRAC_BITS       = 8;
   localparam int MAX_LEN_DEFAULT = 65536;
   localparam int WSTART_W        = 16;
   localparam int WEND_W          = 17;
   localparam int WEND_RESET      = 65536;
   localparam int CSR_DATA_W      = 17;
   localparam int CSR_IDX_W       = 1;
   localparam int POS_W           = 24;
   localparam int MAG_OUT_W       = 24;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_START = 1'b0,
      CSR_WINDOW_END   = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      BK_IDLE  = 4'b0001,
      BK_SETUP = 4'b0010,
      BK_DIV   = 4'b0100,
      BK_DONE  = 4'b1000
   } back_state_type;

endpackage

### src/wppr_req_if.sv
// Sample channel: valid/ready with one correlation sample per transaction.
// Depends on wppr_pkg for the sample width.
`timescale 1ns / 1ps

interface wppr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [wppr_pkg::SAMPLE_BITS-1:0] sample;
   logic                                 last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

### src/wppr_rsp_if.sv
// Result channel: valid/ready with one peak report per transaction.
// Depends on wppr_pkg for the field widths.
`timescale 1ns / 1ps

interface wppr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [wppr_pkg::POS_W-1:0]      peak_position;
   logic [wppr_pkg::MAG_OUT_W-1:0]  peak_magnitude;
   logic                            refined;

   modport source (output valid, output peak_position, output peak_magnitude,
                   output refined, input ready);
   modport sink   (input valid, input peak_position, input peak_magnitude,
                   input refined, output ready);
endinterface

### src/wppr_front.sv
// Front end: window registers, per-sample peak tracking, job issue at frame end.
// Depends on wppr_pkg and wppr_req_if.
`timescale 1ns / 1ps

module wppr_front #(
   parameter int MAX_LEN = wppr_pkg::MAX_LEN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [wppr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wppr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   wppr_req_if.sink                           req,
   output logic                               job_valid,
   input  logic                               job_ready,
   output logic [3*wppr_pkg::SAMPLE_BITS+$clog2(MAX_LEN):0] job_data
);

   localparam int SB    = wppr_pkg::SAMPLE_BITS;
   localparam int IDX_W = $clog2(MAX_LEN + 1);
   localparam int BI_W  = $clog2(MAX_LEN);
   localparam int CMP_W = (IDX_W > wppr_pkg::WEND_W) ? IDX_W : wppr_pkg::WEND_W;

   logic [wppr_pkg::WSTART_W-1:0] ws_ff;
   logic [wppr_pkg::WEND_W-1:0]   we_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SB-1:0]    best_ff, best_in;
   logic [BI_W-1:0]  bidx_ff, bidx_in;
   logic [SB-1:0]    left_ff, left_in;
   logic [SB-1:0]    right_ff, right_in;
   logic             rv_ff, rv_in;
   logic [SB-1:0]    prev_ff;

   logic [SB-1:0]    mag;
   logic [CMP_W-1:0] idx_ext;
   logic [CMP_W-1:0] end_eff;
   logic             in_win;
   logic             capture;
   logic             fire;
   logic             can_refine;

   always_comb begin
      mag     = req.sample[SB-1] ? (~req.sample + 1'b1) : req.sample;
      idx_ext = CMP_W'(idx_ff);
      end_eff = (CMP_W'(we_ff) < CMP_W'(MAX_LEN)) ? CMP_W'(we_ff) : CMP_W'(MAX_LEN);
      in_win  = (idx_ext >= CMP_W'(ws_ff)) && (idx_ext < end_eff);
      capture = (best_ff != '0) && !rv_ff && (idx_ext == CMP_W'(bidx_ff) + CMP_W'(1))
                && (idx_ext < end_eff);

      best_in  = best_ff;
      bidx_in  = bidx_ff;
      left_in  = left_ff;
      right_in = right_ff;
      rv_in    = rv_ff;
      if (capture) begin
         right_in = mag;
         rv_in    = 1'b1;
      end
      if (in_win && (mag > best_ff)) begin
         best_in  = mag;
         bidx_in  = idx_ff[BI_W-1:0];
         left_in  = prev_ff;
         right_in = '0;
         rv_in    = 1'b0;
      end
      idx_in = (idx_ff < IDX_W'(MAX_LEN)) ? idx_ff + IDX_W'(1) : idx_ff;

      can_refine = (best_in != '0) && (CMP_W'(bidx_in) > CMP_W'(ws_ff)) && rv_in;
   end

   assign fire      = req.valid && job_ready;
   assign req.ready = job_ready;
   assign job_valid = fire && req.last;
   assign job_data  = {can_refine, right_in, left_in, best_in, bidx_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= '0;
         we_ff <= wppr_pkg::WEND_W'(wppr_pkg::WEND_RESET);
      end else if (csr_we) begin
         unique case (wppr_pkg::csr_index_type'(csr_index))
            wppr_pkg::CSR_WINDOW_START: ws_ff <= csr_wdata[wppr_pkg::WSTART_W-1:0];
            wppr_pkg::CSR_WINDOW_END:   we_ff <= csr_wdata[wppr_pkg::WEND_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && req.last)) begin
         idx_ff   <= '0;
         best_ff  <= '0;
         bidx_ff  <= '0;
         left_ff  <= '0;
         right_ff <= '0;
         rv_ff    <= 1'b0;
         prev_ff  <= '0;
      end else if (fire) begin
         idx_ff   <= idx_in;
         best_ff  <= best_in;
         bidx_ff  <= bidx_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         rv_ff    <= rv_in;
         prev_ff  <= mag;
      end
   end

endmodule

### src/wppr_queue.sv
// Small job queue between the front end and the divider back end.
// Depends on wppr_pkg for the default depth.
`timescale 1ns / 1ps

module wppr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = wppr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff < CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

### src/wppr_back.sv
// Back end: parabolic offset by restoring division, position assembly, result register.
// Depends on wppr_pkg, wppr_rsp_if and the assertion macro header.
`timescale 1ns / 1ps
`include "windowed_peak_with_parabolic_refine_core_macros.svh"

module wppr_back #(
   parameter int MAX_LEN = wppr_pkg::MAX_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  logic [3*wppr_pkg::SAMPLE_BITS+$clog2(MAX_LEN):0] job_data,
   wppr_rsp_if.source  rsp
);

   localparam int SB    = wppr_pkg::SAMPLE_BITS;
   localparam int F     = wppr_pkg::FRAC_BITS;
   localparam int BI_W  = $clog2(MAX_LEN);
   localparam int Q_W   = F + 1;
   localparam int CNT_W = $clog2(Q_W);
   localparam int DIV_W = SB + F + 5;
   localparam int PW    = ((BI_W + F > wppr_pkg::POS_W) ? BI_W + F : wppr_pkg::POS_W) + 1;
   localparam logic [Q_W-1:0] Q_MAX = Q_W'(1) << (F - 1);

   wppr_pkg::back_state_type st_ff, st_in;

   logic [BI_W-1:0]  idx_ff;
   logic [SB-1:0]    mag_ff, left_ff, right_ff;
   logic             can_ff;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsh_ff, dsh_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             refine_ff, refine_in;

   logic [wppr_pkg::POS_W-1:0]     pos_out_ff;
   logic [wppr_pkg::MAG_OUT_W-1:0] mag_out_ff;
   logic                           ref_out_ff;
   logic                           rsp_valid_ff;

   logic signed [SB:0]   diff_ad;
   logic signed [SB+2:0] den;
   logic [SB:0]          abs_ad;
   logic [SB+2:0]        abs_den;
   logic [SB+F-1:0]      un;
   logic                 ge;
   logic [PW-1:0]        base, pos_full;
   logic                 out_free;
   logic                 load_out;

   assign job_ready = (st_ff == wppr_pkg::BK_IDLE);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign load_out  = (st_ff == wppr_pkg::BK_DONE) && out_free;

   always_comb begin
      diff_ad = $signed({1'b0, left_ff}) - $signed({1'b0, right_ff});
      den     = $signed({3'b000, left_ff}) - $signed({2'b00, mag_ff, 1'b0})
                + $signed({3'b000, right_ff});
      abs_ad  = diff_ad[SB] ? (~diff_ad + 1'b1) : diff_ad;
      abs_den = den[SB+2] ? (~den + 1'b1) : den;
      un      = {abs_ad, {(F-1){1'b0}}};
      ge      = (rem_ff >= dsh_ff);

      base     = PW'(idx_ff) << F;
      pos_full = !refine_ff ? base
               : (neg_ff ? base - PW'(q_ff) : base + PW'(q_ff));

      st_in     = st_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      refine_in = refine_ff;

      unique case (st_ff)
         wppr_pkg::BK_IDLE: begin
            if (job_valid) begin
               st_in = wppr_pkg::BK_SETUP;
            end
         end
         wppr_pkg::BK_SETUP: begin
            refine_in = can_ff && (den != '0);
            neg_in    = diff_ad[SB] ^ den[SB+2];
            rem_in    = (DIV_W'(un) << 1) + DIV_W'(abs_den);
            dsh_in    = DIV_W'(abs_den) << Q_W;
            q_in      = '0;
            cnt_in    = CNT_W'(Q_W - 1);
            st_in     = (can_ff && (den != '0)) ? wppr_pkg::BK_DIV : wppr_pkg::BK_DONE;
         end
         wppr_pkg::BK_DIV: begin
            rem_in = ge ? rem_ff - dsh_ff : rem_ff;
            q_in   = {q_ff[Q_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               st_in = wppr_pkg::BK_DONE;
            end
         end
         wppr_pkg::BK_DONE: begin
            if (out_free) begin
               st_in = wppr_pkg::BK_IDLE;
            end
         end
         default: st_in = wppr_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= wppr_pkg::BK_IDLE;
         refine_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         refine_ff <= refine_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (job_valid && job_ready) begin
         idx_ff   <= job_data[BI_W-1:0];
         mag_ff   <= job_data[BI_W +: SB];
         left_ff  <= job_data[BI_W+SB +: SB];
         right_ff <= job_data[BI_W+2*SB +: SB];
         can_ff   <= job_data[BI_W+3*SB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         pos_out_ff <= pos_full[wppr_pkg::POS_W-1:0];
         mag_out_ff <= wppr_pkg::MAG_OUT_W'(mag_ff);
         ref_out_ff <= refine_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.peak_position  = pos_out_ff;
   assign rsp.peak_magnitude = mag_out_ff;
   assign rsp.refined        = ref_out_ff;

   `WPPR_ASSERT_NEXT(a_pop_starts_setup, clock, reset, job_valid && job_ready, st_ff == wppr_pkg::BK_SETUP, "job pop did not start setup")
   `WPPR_ASSERT_NEXT(a_div_ends, clock, reset, (st_ff == wppr_pkg::BK_DIV) && (cnt_ff == '0), st_ff == wppr_pkg::BK_DONE, "divider overran its step count")
   `WPPR_ASSERT_SAME(a_offset_bound, clock, reset, (st_ff == wppr_pkg::BK_DONE) && refine_ff, q_ff <= Q_MAX, "parabolic offset exceeds half a sample")
   `WPPR_ASSERT_SAME(a_refined_has_peak, clock, reset, rsp.valid && rsp.refined, rsp.peak_magnitude != '0, "refined result without a peak")

endmodule

### src/windowed_peak_with_parabolic_refine_core.sv
// Samples: one per cycle, ready stays high unless the two-entry job queue is full.
// Result: the frame's last sample queues a job; the back end pops it, sets up, runs
// 9 restoring divide steps if refined, and adds position into the result register.
// Back end takes a new frame job only once the last result is loaded for output.
// Reset (synchronous, active high): window 0..65536, frame state and queue cleared.
`timescale 1ns / 1ps

module windowed_peak_with_parabolic_refine_core #(
   parameter int MAX_LEN = wppr_pkg::MAX_LEN_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [wppr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wppr_pkg::CSR_DATA_W-1:0] csr_wdata,
   wppr_req_if.sink                        req_ch,
   wppr_rsp_if.source                      rsp_ch
);

   localparam int JOB_W = 3 * wppr_pkg::SAMPLE_BITS + $clog2(MAX_LEN) + 1;

   logic             fr_valid, fr_ready;
   logic [JOB_W-1:0] fr_data;
   logic             bk_valid, bk_ready;
   logic [JOB_W-1:0] bk_data;

   wppr_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .job_valid (fr_valid),
      .job_ready (fr_ready),
      .job_data  (fr_data)
   );

   wppr_queue #(.WIDTH(JOB_W), .DEPTH(wppr_pkg::QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_data),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_data   (bk_data)
   );

   wppr_back #(.MAX_LEN(MAX_LEN)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (bk_valid),
      .job_ready (bk_ready),
      .job_data  (bk_data),
      .rsp       (rsp_ch)
   );

endmodule
